>>> src/magnetometer_compass_heading_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the magnetometer compass heading block
// Short forms for clocked implication checks on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_COMPASS_HEADING_ASSERT_SVH
`define MAGNETOMETER_COMPASS_HEADING_ASSERT_SVH

// Same-cycle implication: cond at an edge implies prop at that edge.
`define MCH_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("magnetometer heading: same-cycle check failed");

// Next-cycle implication: cond at an edge implies prop at the following edge.
`define MCH_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("magnetometer heading: next-cycle check failed");

`endif

>>> src/mch_pkg.sv
// ----------------------------------------------------------------------------
// mch_pkg
// Shared widths, arctangent table and stage payload for the heading pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mch_pkg;

   // Requested CORDIC iterations (8..24); the table caps the effective count.
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int STEPS        = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   localparam int AXIS_W   = 16;   // packed axis value
   localparam int SCALE_SH = 24;   // vector pre-scale, 2^24
   localparam int VEC_W    = 42;   // CORDIC vector, holds |v| * gain * 2^24
   localparam int ANG_W    = 25;   // angle, degrees Q16
   localparam int TAB_W    = 22;   // table entry width
   localparam int FRAC_W   = 16;   // angle fraction bits
   localparam int HF_W     = 27;   // heading before flooring, degrees Q16
   localparam int HQ_W     = HF_W - 1 - FRAC_W;
   localparam int HEAD_W   = 9;

   localparam int REQ_W = 32;
   localparam int RSP_W = 48;

   // atan(2^-i) in degrees, Q16, rounded to nearest
   localparam logic [TAB_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
      22'd234379,  22'd117304,  22'd58666,  22'd29335,
      22'd14668,   22'd7334,    22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,
      22'd57,      22'd29,      22'd14,     22'd7,
      22'd4,       22'd2,       22'd1,      22'd0
   };

   localparam logic signed [HF_W-1:0] DEG90_Q  = HF_W'(90 * 65536);
   localparam logic signed [HF_W-1:0] DEG180_Q = HF_W'(180 * 65536);
   localparam logic signed [HF_W-1:0] DEG270_Q = HF_W'(270 * 65536);

   localparam logic [HEAD_W-1:0] HEAD_NORTH = 9'd0;
   localparam logic [HEAD_W-1:0] HEAD_SOUTH = 9'd180;
   localparam logic [HQ_W-1:0]   HQ_EAST_MAX = 10'd179;
   localparam logic [HQ_W-1:0]   HQ_WEST_MAX = 10'd359;

   typedef struct packed {
      logic [AXIS_W-1:0]        axis_x;
      logic [AXIS_W-1:0]        axis_y;
      logic                     y_zero;
      logic                     y_neg;
      logic                     x_neg;
      logic signed [VEC_W-1:0]  vx;
      logic signed [VEC_W-1:0]  vy;
      logic signed [ANG_W-1:0]  z;
   } stage_type;

endpackage

`default_nettype wire

>>> src/mch_prep.sv
// ----------------------------------------------------------------------------
// mch_prep
// Input stage: pack the axis bytes and load the scaled CORDIC start vector.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_prep (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [mch_pkg::REQ_W-1:0]  req_tdata,
   output logic                            out_valid,
   output mch_pkg::stage_type              out_data,
   input  wire logic                       out_ready
);

   logic                        valid_ff;
   logic                        valid_in;
   mch_pkg::stage_type          data_ff;
   mch_pkg::stage_type          data_in;
   logic [mch_pkg::AXIS_W-1:0]  x_bits;
   logic [mch_pkg::AXIS_W-1:0]  y_bits;
   logic [mch_pkg::AXIS_W:0]    y_mag;

   always_comb begin
      x_bits = req_tdata[mch_pkg::AXIS_W-1:0];
      y_bits = req_tdata[2*mch_pkg::AXIS_W-1:mch_pkg::AXIS_W];
      // negate the sign-extended value so the magnitude fits in 17 bits
      y_mag  = y_bits[mch_pkg::AXIS_W-1] ? ((mch_pkg::AXIS_W+1)'(0) - {1'b1, y_bits})
                                         : {1'b0, y_bits};
      data_in.axis_x = x_bits;
      data_in.axis_y = y_bits;
      data_in.y_zero = (y_bits == '0);
      data_in.y_neg  = y_bits[mch_pkg::AXIS_W-1];
      data_in.x_neg  = x_bits[mch_pkg::AXIS_W-1];
      data_in.vx = $signed({{(mch_pkg::VEC_W-mch_pkg::AXIS_W-1-mch_pkg::SCALE_SH){1'b0}},
                            y_mag, {mch_pkg::SCALE_SH{1'b0}}});
      data_in.vy = $signed({{(mch_pkg::VEC_W-mch_pkg::AXIS_W-mch_pkg::SCALE_SH)
                             {x_bits[mch_pkg::AXIS_W-1]}},
                            x_bits, {mch_pkg::SCALE_SH{1'b0}}});
      data_in.z  = '0;
   end

   assign req_tready = !valid_ff || out_ready;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> src/mch_cordic.sv
// ----------------------------------------------------------------------------
// mch_cordic
// Vectoring CORDIC, one registered stage per iteration, elastic valid chain.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire mch_pkg::stage_type in_data,
   output logic                    out_valid,
   output mch_pkg::stage_type      out_data,
   input  wire logic               out_ready
);

   logic [mch_pkg::STEPS-1:0] valid_ff;
   logic [mch_pkg::STEPS-1:0] valid_in;
   logic [mch_pkg::STEPS:0]   valid_at;
   logic [mch_pkg::STEPS:0]   rdy;
   mch_pkg::stage_type        data_ff [mch_pkg::STEPS];
   mch_pkg::stage_type        data_in [mch_pkg::STEPS];
   mch_pkg::stage_type        data_at [mch_pkg::STEPS+1];

   assign valid_at[0]           = in_valid;
   assign data_at[0]            = in_data;
   assign rdy[mch_pkg::STEPS]   = out_ready;

   for (genvar k = 0; k < mch_pkg::STEPS; k++) begin : g_step
      localparam logic signed [mch_pkg::ANG_W-1:0] STEP_ANG =
         mch_pkg::ANG_W'(mch_pkg::ATAN_TABLE[k]);

      // rotate toward the x axis; shifts floor like the arithmetic shift
      always_comb begin
         data_in[k] = data_at[k];
         if (data_at[k].vy > 0) begin
            data_in[k].vx = data_at[k].vx + (data_at[k].vy >>> k);
            data_in[k].vy = data_at[k].vy - (data_at[k].vx >>> k);
            data_in[k].z  = data_at[k].z + STEP_ANG;
         end else begin
            data_in[k].vx = data_at[k].vx - (data_at[k].vy >>> k);
            data_in[k].vy = data_at[k].vy + (data_at[k].vx >>> k);
            data_in[k].z  = data_at[k].z - STEP_ANG;
         end
      end

      assign rdy[k]        = !valid_ff[k] || rdy[k+1];
      assign valid_in[k]   = rdy[k] ? valid_at[k] : valid_ff[k];
      assign valid_at[k+1] = valid_ff[k];
      assign data_at[k+1]  = data_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && valid_at[k]) begin
            data_ff[k] <= data_in[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_at[mch_pkg::STEPS];
   assign out_data  = data_at[mch_pkg::STEPS];

endmodule

`default_nettype wire

>>> src/mch_heading.sv
// ----------------------------------------------------------------------------
// mch_heading
// Output stage: map the CORDIC angle to a floored, clamped compass heading.
// ----------------------------------------------------------------------------
`default_nettype none

module mch_heading (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire mch_pkg::stage_type          in_data,
   output logic                             out_valid,
   output logic [mch_pkg::HEAD_W-1:0]       heading_deg,
   output logic [mch_pkg::AXIS_W-1:0]       axis_x,
   output logic [mch_pkg::AXIS_W-1:0]       axis_y,
   input  wire logic                        out_ready
);

   logic                             valid_ff;
   logic                             valid_in;
   logic [mch_pkg::HEAD_W-1:0]       heading_ff;
   logic [mch_pkg::HEAD_W-1:0]       heading_in;
   logic [mch_pkg::AXIS_W-1:0]       axis_x_ff;
   logic [mch_pkg::AXIS_W-1:0]       axis_y_ff;
   logic signed [mch_pkg::HF_W-1:0]  z_ext;
   logic signed [mch_pkg::HF_W-1:0]  hf;
   logic [mch_pkg::HQ_W-1:0]         hq;

   always_comb begin
      z_ext      = mch_pkg::HF_W'(in_data.z);
      hf         = '0;
      hq         = '0;
      heading_in = mch_pkg::HEAD_NORTH;
      if (in_data.y_zero) begin
         heading_in = in_data.x_neg ? mch_pkg::HEAD_SOUTH : mch_pkg::HEAD_NORTH;
      end else if (!in_data.y_neg) begin
         // east half: keep the result within 0..179
         hf = mch_pkg::DEG90_Q - z_ext;
         if (hf < 0) begin
            hf = '0;
         end
         hq = hf[mch_pkg::HF_W-2:mch_pkg::FRAC_W];
         if (hq > mch_pkg::HQ_EAST_MAX) begin
            hq = mch_pkg::HQ_EAST_MAX;
         end
         heading_in = mch_pkg::HEAD_W'(hq);
      end else begin
         // west half: keep the result within 180..359
         hf = mch_pkg::DEG270_Q + z_ext;
         if (hf < mch_pkg::DEG180_Q) begin
            hf = mch_pkg::DEG180_Q;
         end
         hq = hf[mch_pkg::HF_W-2:mch_pkg::FRAC_W];
         if (hq > mch_pkg::HQ_WEST_MAX) begin
            hq = mch_pkg::HQ_WEST_MAX;
         end
         heading_in = mch_pkg::HEAD_W'(hq);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         heading_ff <= heading_in;
         axis_x_ff  <= in_data.axis_x;
         axis_y_ff  <= in_data.axis_y;
      end
   end

   assign out_valid   = valid_ff;
   assign heading_deg = heading_ff;
   assign axis_x      = axis_x_ff;
   assign axis_y      = axis_y_ff;

endmodule

`default_nettype wire

>>> src/magnetometer_compass_heading.sv
// Pipeline from an accepted req transaction to rsp_tvalid: 1 input stage,
//   16 CORDIC iteration stages, 1 heading stage.
// Throughput: one transaction per cycle while rsp_tready is high; each CORDIC iteration owns a stage.
// Every stage holds its item under backpressure and takes a new one when empty.
// Reset: synchronous, active high; clears all stage valid bits, data is kept.
// ----------------------------------------------------------------------------
// magnetometer_compass_heading
// Compass heading in whole degrees from raw magnetometer X/Y byte pairs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "magnetometer_compass_heading_assert.svh"

module magnetometer_compass_heading (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // req_tdata fields, low bit up: x_low[7:0], x_high[15:8], y_low[23:16],
   // y_high[31:24]
   input  wire logic [mch_pkg::REQ_W-1:0]   req_tdata,
   // response channel
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // rsp_tdata fields, low bit up: heading_deg[8:0], axis_x[24:9],
   // axis_y[40:25], zero pad[47:41]
   output logic [mch_pkg::RSP_W-1:0]        rsp_tdata
);

   // stage-to-stage handshake and payload
   logic                         prep_valid;
   logic                         prep_ready;
   mch_pkg::stage_type           prep_data;
   logic                         cordic_valid;
   logic                         cordic_ready;
   mch_pkg::stage_type           cordic_data;
   logic [mch_pkg::HEAD_W-1:0]   heading_deg;
   logic [mch_pkg::AXIS_W-1:0]   axis_x;
   logic [mch_pkg::AXIS_W-1:0]   axis_y;

   // Pack the axes and build the start vector (|y|, x) scaled by 2^24.
   mch_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_valid  (prep_valid),
      .out_data   (prep_data),
      .out_ready  (prep_ready)
   );

   // Drive the vector onto the x axis; z accumulates atan(x/|y|) in Q16 degrees.
   mch_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (cordic_valid),
      .out_data  (cordic_data),
      .out_ready (cordic_ready)
   );

   // Fold the angle into its half plane, floor and register the response.
   mch_heading u_heading (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cordic_valid),
      .in_ready    (cordic_ready),
      .in_data     (cordic_data),
      .out_valid   (rsp_tvalid),
      .heading_deg (heading_deg),
      .axis_x      (axis_x),
      .axis_y      (axis_y),
      .out_ready   (rsp_tready)
   );

   assign rsp_tdata = {{(mch_pkg::RSP_W - mch_pkg::HEAD_W - 2*mch_pkg::AXIS_W){1'b0}},
                       axis_y, axis_x, heading_deg};

   // An accepted transaction lands in the input stage.
   `MCH_ASSERT_NEXT(a_req_lands, req_tvalid && req_tready, prep_valid)
   // An empty input stage always takes a transaction.
   `MCH_ASSERT_IMP(a_empty_ready, !prep_valid, req_tready)
   // Positive y stays in the eastern half, negative y in the western half.
   `MCH_ASSERT_IMP(a_east_half, rsp_tvalid && !axis_y[mch_pkg::AXIS_W-1] && (axis_y != '0),
                   heading_deg <= 9'd179)
   `MCH_ASSERT_IMP(a_west_half, rsp_tvalid && axis_y[mch_pkg::AXIS_W-1],
                   (heading_deg >= 9'd180) && (heading_deg <= 9'd359))
   // Zero y gives due north or due south only.
   `MCH_ASSERT_IMP(a_y_zero, rsp_tvalid && (axis_y == '0),
                   (heading_deg == mch_pkg::HEAD_NORTH) || (heading_deg == mch_pkg::HEAD_SOUTH))

endmodule

`default_nettype wire
